[rtl/opd_pkg.sv]
`timescale 1ns / 1ps

package opd_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int DCNT_W      = 6;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    typedef struct packed {
        logic load;     // capture a new element, restart the scan
        logic issue;    // read the next stored entry
        logic finish;   // form the result, update the table
    } opd_cmd_t;

    typedef struct packed {
        logic issue_done;   // every valid entry has been read
        logic hit;          // entry in the compare stage matches the element
        logic rd_vld;       // compare stage holds an entry
        logic out_busy;     // result register still holds an untaken beat
    } opd_sts_t;

endpackage

[rtl/opd_ctrl.sv]
`timescale 1ns / 1ps

module opd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  opd_pkg::opd_sts_t sts,
    output opd_pkg::opd_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = !sts.issue_done;
                // stop on a match, or once the last issued entry has been compared
                if (sts.hit || (!sts.rd_vld && sts.issue_done)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/opd_dp.sv]
`timescale 1ns / 1ps

module opd_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  opd_pkg::opd_cmd_t                cmd,
    output opd_pkg::opd_sts_t                sts,
    input  logic [opd_pkg::VAL_W-1:0]        in_value,
    input  logic                             in_last,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [opd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    output logic [opd_pkg::CNT_W-1:0]        count
);

    logic [opd_pkg::VAL_W-1:0] table_mem [opd_pkg::TABLE_DEPTH];

    logic [opd_pkg::VAL_W-1:0]  val_reg;
    logic                       last_reg;
    logic [opd_pkg::CNT_W-1:0]  cnt_reg;
    logic [opd_pkg::CNT_W-1:0]  cnt_next;
    logic [opd_pkg::CNT_W-1:0]  issue_reg;
    logic [opd_pkg::VAL_W-1:0]  rd_data_reg;
    logic                       rd_vld_reg;
    logic                       found_reg;
    logic                       hit;
    logic                       full;
    logic                       store;
    logic [opd_pkg::CNT_W-1:0]  res_cnt;

    logic                       out_vld_reg;
    logic [opd_pkg::VAL_W-1:0]  out_val_reg;
    logic                       out_keep_reg;
    logic                       out_ovf_reg;
    logic [opd_pkg::DCNT_W-1:0] out_cnt_reg;
    logic                       out_last_reg;

    assign hit     = rd_vld_reg && (rd_data_reg == val_reg);
    assign full    = (cnt_reg == opd_pkg::CNT_W'(opd_pkg::TABLE_DEPTH));
    assign store   = !found_reg && !full;
    assign res_cnt = store ? cnt_reg + opd_pkg::CNT_W'(1) : cnt_reg;
    assign cnt_next = last_reg ? '0 : res_cnt;

    assign sts.issue_done = (issue_reg == cnt_reg);
    assign sts.hit        = hit;
    assign sts.rd_vld     = rd_vld_reg;
    assign sts.out_busy   = out_vld_reg && !m_tready;

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.finish && store) begin
            table_mem[cnt_reg[opd_pkg::IDX_W-1:0]] <= val_reg;
        end
        if (cmd.issue) begin
            rd_data_reg <= table_mem[issue_reg[opd_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg  <= in_value;
            last_reg <= in_last;
        end
        if (cmd.finish) begin
            out_val_reg  <= val_reg;
            out_keep_reg <= store;
            out_ovf_reg  <= !found_reg && full;
            out_cnt_reg  <= opd_pkg::DCNT_W'(res_cnt);
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            issue_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.issue;
            if (cmd.load) begin
                issue_reg <= '0;
                found_reg <= 1'b0;
            end else begin
                if (cmd.issue) begin
                    issue_reg <= issue_reg + opd_pkg::CNT_W'(1);
                end
                found_reg <= found_reg | hit;
            end
            if (cmd.finish) begin
                cnt_reg     <= cnt_next;
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_cnt_reg, out_ovf_reg, out_keep_reg, out_val_reg};
    assign m_tlast  = out_last_reg;
    assign count    = cnt_reg;

endmodule

[rtl/order_preserving_dedup.sv]
`timescale 1ns / 1ps

// channel | dir | tdata                                              | tlast
// s_      | in  | [31:0] elem_value                                   | elem_last
// m_      | out | [31:0] out_value, [32] keep, [33] overflow,        | out_last
//         |     | [39:34] distinct_count, 40 bits                    |
//
// Each element passes through accept, a scan of the stored distinct values at one
// entry per cycle through the table's single read port, a drain of the last read
// and compare, and a result cycle. The scan stops early on a match.
// Reset clears the count, so the table starts empty; its contents need no clear.
// The result sits in an output register; a stalled m_ side holds the block in
// its result cycle, while s_tready rises again as soon as the result is written.

module order_preserving_dedup (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [opd_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] elem_value
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [opd_pkg::M_TDATA_W-1:0]     m_tdata,   // value, keep, overflow, count
    output logic                              m_tlast
);

    opd_pkg::opd_cmd_t          cmd;
    opd_pkg::opd_sts_t          sts;
    logic [opd_pkg::CNT_W-1:0]  count;

    opd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    opd_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_value (s_tdata[opd_pkg::VAL_W-1:0]),
        .in_last  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .count    (count)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= opd_pkg::CNT_W'(opd_pkg::TABLE_DEPTH))
        else $error("distinct count above table depth");

    a_keep_ovf_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
        else $error("keep and overflow both set");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33]) |->
            (m_tdata[39:34] == opd_pkg::DCNT_W'(opd_pkg::TABLE_DEPTH)))
        else $error("overflow reported below full table");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second element taken during a scan");

    a_finish_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> !cmd.finish)
        else $error("result written twice for one element");

endmodule

[dv/tb_order_preserving_dedup.sv]
`timescale 1ns / 1ps

module tb_order_preserving_dedup;

    import opd_pkg::*;

    localparam int IDLE_LIMIT = 1000;   // cycles with no beat on either side
    localparam int TAIL_WAIT  = 40;     // a full scan plus a result cycle, with margin
    localparam int RAND_ITEMS = 1800;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic              keep;
        logic              ovf;
        logic [DCNT_W-1:0] count;
        logic              last;
    } dedup_res_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [31:0] elem_value
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [31:0] value, [32] keep, [33] overflow,
                                            // [39:34] distinct_count
    logic                 m_tlast;

    // predictor state: distinct values of the open sequence
    logic [VAL_W-1:0] uniq_vals [TABLE_DEPTH];
    int               uniq_cnt = 0;

    dedup_res_t pending_q [$];

    int errors     = 0;
    int n_elems    = 0;
    int n_seqs     = 0;
    int n_kept     = 0;
    int n_ovf      = 0;
    int n_results  = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    order_preserving_dedup dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic dedup_res_t predict_dedup(logic [VAL_W-1:0] v, logic l);
        dedup_res_t r;
        logic       hit;
        hit = 1'b0;
        for (int i = 0; i < uniq_cnt; i++)
            if (uniq_vals[i] == v) hit = 1'b1;
        r.value = v;
        r.keep  = 1'b0;
        r.ovf   = 1'b0;
        if (!hit) begin
            if (uniq_cnt < TABLE_DEPTH) begin
                uniq_vals[uniq_cnt] = v;
                uniq_cnt++;
                r.keep = 1'b1;
            end else begin
                r.ovf = 1'b1;
            end
        end
        r.count = DCNT_W'(uniq_cnt);
        r.last  = l;
        if (l) uniq_cnt = 0;
        return r;
    endfunction

    // one beat on s_, opening a new burst (and maybe a gap) when the last one ran out
    task automatic send_elem(input logic [VAL_W-1:0] v, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_q.push_back(predict_dedup(v, l));
        n_elems++;
        if (l) n_seqs++;
    endtask

    // receiver: ready runs alternating with stall runs, some stall-free
    always @(posedge aclk) begin
        static int rdy_run = 0;
        static int stall_run = 0;
        logic      nxt;
        if (rdy_run == 0 && stall_run == 0) begin
            rdy_run   = $urandom_range(1, 40);
            stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
        if (rdy_run > 0) begin
            nxt = 1'b1;
            rdy_run--;
        end else begin
            nxt = 1'b0;
            stall_run--;
        end
        m_tready <= nxt;
    end

    task automatic compare_field(input string name, input logic [31:0] e,
                                 input logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, e, a);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        dedup_res_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result beat, actual %h last %b",
                         $realtime, m_tdata, m_tlast);
                errors++;
            end else begin
                exp_r = pending_q.pop_front();
                compare_field("value", exp_r.value, m_tdata[31:0]);
                compare_field("keep", 32'(exp_r.keep), 32'(m_tdata[32]));
                compare_field("overflow", 32'(exp_r.ovf), 32'(m_tdata[33]));
                compare_field("distinct_count", 32'(exp_r.count), 32'(m_tdata[39:34]));
                compare_field("last", 32'(exp_r.last), 32'(m_tlast));
                if (exp_r.keep) n_kept++;
                if (exp_r.ovf) n_ovf++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $realtime, IDLE_LIMIT, pending_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed;
        send_elem(32'h0000_0000, 1'b0);
        send_elem(32'h0000_0000, 1'b0);     // repeat
        send_elem(32'hFFFF_FFFF, 1'b0);
        send_elem(32'h8000_0000, 1'b0);
        send_elem(32'h7FFF_FFFF, 1'b0);
        send_elem(32'h8000_0000, 1'b0);
        send_elem(32'h0000_0000, 1'b0);
        send_elem(32'h7FFF_FFFF, 1'b1);
        // table must be empty again
        send_elem(32'h0000_0000, 1'b1);
        send_elem(32'h5555_5555, 1'b0);
        send_elem(32'hAAAA_AAAA, 1'b0);
        send_elem(32'h5555_5555, 1'b0);
        send_elem(32'hAAAA_AAAA, 1'b1);
        send_elem(32'h0000_0001, 1'b1);
        send_elem(32'h0000_0001, 1'b1);
        send_elem(32'hFFFF_FFFE, 1'b0);
        send_elem(32'hFFFF_FFFE, 1'b1);     // repeat on the last beat
    endtask

    task automatic test_table_full;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_elem(32'h1000_0000 + i * 32'h0101_0101, 1'b0);
        send_elem(32'hDEAD_BEEF, 1'b0);     // new value, table full
        send_elem(32'hDEAD_BEEF, 1'b0);     // not stored, so overflows again
        send_elem(32'h1000_0000, 1'b0);     // stored value still found
        send_elem(32'hFFFF_FFFF, 1'b1);     // overflow on the last beat
        send_elem(32'hDEAD_BEEF, 1'b1);
    endtask

    task automatic test_random;
        logic [VAL_W-1:0] pool [48];
        int               pool_size;
        int               seq_len;
        int               sent;
        int               pick;
        logic [VAL_W-1:0] v;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                seq_len = $urandom_range(1, 34);
            else if (pick < 9)
                seq_len = $urandom_range(33, 45);
            else
                seq_len = $urandom_range(1, 3);
            pool_size = $urandom_range(1, 48);
            for (int i = 0; i < pool_size; i++) begin
                case ($urandom_range(0, 7))
                    0:       pool[i] = 32'h8000_0000;
                    1:       pool[i] = 32'h7FFF_FFFF;
                    2:       pool[i] = $urandom_range(0, 3);
                    default: pool[i] = $urandom;
                endcase
            end
            for (int j = 0; j < seq_len; j++) begin
                if ($urandom_range(0, 3) == 0)
                    v = $urandom;
                else
                    v = pool[$urandom_range(0, pool_size - 1)];
                send_elem(v, j == seq_len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_table_full();
        test_random();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        $display("Sent %0d elements in %0d sequences, checked %0d results.",
                 n_elems, n_seqs, n_results);
        $display("Kept %0d first occurrences, saw %0d table-full overflows.", n_kept, n_ovf);
        if (errors == 0 && pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
